/* src/tpq_pkg.sv */
// Shared types and constants of the timer priority queue.
package tpq_pkg;

   localparam int TIME_W = 63;
   localparam int PER_W  = 40;
   localparam int SLOT_W = 5;
   localparam int GEN_W  = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_CANCEL  = 2'd2,
      KIND_FIN     = 2'd3
   } kind_type;

   // What the slot scan looks for.
   typedef enum logic [1:0] {
      SCAN_PLAIN,
      SCAN_NEXT,
      SCAN_DUE
   } scan_mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_SCAN,
      S_ADD_FIN,
      S_CAN_DO,
      S_CAN_SCAN,
      S_CAN_FIN,
      S_TNEXT_SCAN,
      S_TPREP,
      S_TDUE_SCAN,
      S_TPICK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          latch;
      logic          scan_clear;
      logic          scan_step;
      scan_mode_type scan_mode;
      logic          cancel_do;
      logic          pick_update;
      logic          tick_save;
      logic          emit;
      kind_type      emit_kind;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic any;
   } dp_status_type;

endpackage

/* src/tpq_datapath.sv */
// Slot stores, scan unit and result registers of the timer priority queue.
module tpq_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_cmd,
   input  logic [tpq_pkg::TIME_W-1:0]  req_time_value,
   input  logic [tpq_pkg::PER_W-1:0]   req_repeat_interval,
   input  logic [tpq_pkg::SLOT_W-1:0]  req_handle_slot,
   input  logic [tpq_pkg::GEN_W-1:0]   req_handle_generation,
   input  tpq_pkg::dp_cmd_type         dp_cmd,
   output tpq_pkg::dp_status_type      dp_status,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_result_kind,
   output logic [tpq_pkg::SLOT_W-1:0]  rsp_out_slot,
   output logic [tpq_pkg::GEN_W-1:0]   rsp_out_generation,
   output logic                        rsp_success,
   output logic                        rsp_became_earliest,
   output logic [tpq_pkg::TIME_W-1:0]  rsp_next_expiry,
   output logic                        rsp_next_valid,
   output logic                        rsp_last
);

   localparam int IW = $clog2(CAPACITY);
   localparam int TW = tpq_pkg::TIME_W;
   localparam int PW = tpq_pkg::PER_W;
   localparam int GW = tpq_pkg::GEN_W;
   localparam int SW = tpq_pkg::SLOT_W;

   // Slot stores.
   logic [CAPACITY-1:0] live_ff, picked_ff;
   logic [GW-1:0]       gen_ff [CAPACITY];
   logic [TW-1:0]       exp_ff [CAPACITY];
   logic [PW-1:0]       per_ff [CAPACITY];

   // Latched request.
   tpq_pkg::cmd_type cmd_ff;
   logic [TW-1:0]    tv_ff;
   logic [PW-1:0]    ri_ff;
   logic [SW-1:0]    hs_ff;
   logic [GW-1:0]    hg_ff;

   // Scan state.
   logic [IW-1:0] idx_ff, best_slot_ff;
   logic          any_ff, ok_ff, nv_ff;
   logic [TW-1:0] best_ff, nxt_ff;
   logic [PW-1:0] best_per_ff;

   function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [PW-1:0] b);
      logic [TW:0] sum;
      sum = {1'b0, a} + (TW+1)'(b);
      return sum[TW] ? tpq_pkg::TIME_MAX : sum[TW-1:0];
   endfunction

   logic          rd_live, rd_pick, due_i, cand, better, found, hs_ok, hit, early;
   logic [TW-1:0] rd_exp, val, add_next, resched;
   logic [PW-1:0] rd_per;
   logic [IW-1:0] free_idx, hs_idx, gen_addr;
   logic [GW-1:0] gen_rd;

   // Read at the scan index and qualify the candidate.
   always_comb begin
      rd_live = live_ff[idx_ff];
      rd_pick = picked_ff[idx_ff];
      rd_exp  = exp_ff[idx_ff];
      rd_per  = per_ff[idx_ff];
      due_i   = rd_live && (rd_exp <= tv_ff);
      unique case (dp_cmd.scan_mode)
         tpq_pkg::SCAN_NEXT: begin
            cand = rd_live && !(due_i && (rd_per == '0));
            val  = due_i ? sat_add(tv_ff, rd_per) : rd_exp;
         end
         tpq_pkg::SCAN_DUE: begin
            cand = due_i && !rd_pick;
            val  = rd_exp;
         end
         default: begin
            cand = rd_live;
            val  = rd_exp;
         end
      endcase
      better = cand && (!any_ff || (val < best_ff));
   end

   // Lowest free slot.
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            found    = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // Cancel match, generation read and add summary.
   always_comb begin
      hs_idx = IW'(hs_ff);
      hs_ok  = (32'(hs_ff) < CAPACITY);
      case (cmd_ff)
         tpq_pkg::CMD_ADD:    gen_addr = free_idx;
         tpq_pkg::CMD_CANCEL: gen_addr = hs_idx;
         default:             gen_addr = best_slot_ff;
      endcase
      gen_rd   = gen_ff[gen_addr];
      hit      = hs_ok && live_ff[hs_idx] && (gen_rd == hg_ff);
      early    = found && (!any_ff || (tv_ff < best_ff));
      if (any_ff) begin
         add_next = early ? tv_ff : best_ff;
      end else begin
         add_next = found ? tv_ff : '0;
      end
      resched  = sat_add(tv_ff, best_per_ff);
   end

   assign dp_status.scan_last = (idx_ff == IW'(CAPACITY - 1));
   assign dp_status.any       = any_ff;

   // Control state and valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= '0;
         picked_ff <= '0;
         rsp_valid <= 1'b0;
         idx_ff    <= '0;
         any_ff    <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            gen_ff[i] <= '0;
         end
      end else begin
         rsp_valid <= dp_cmd.emit;
         if (dp_cmd.latch) begin
            picked_ff <= '0;
         end
         if (dp_cmd.scan_clear) begin
            idx_ff <= '0;
            any_ff <= 1'b0;
         end else if (dp_cmd.scan_step) begin
            idx_ff <= dp_status.scan_last ? '0 : idx_ff + 1'b1;
            if (better) begin
               any_ff <= 1'b1;
            end
         end
         if (dp_cmd.cancel_do && hit) begin
            live_ff[hs_idx] <= 1'b0;
         end
         if (dp_cmd.pick_update) begin
            picked_ff[best_slot_ff] <= 1'b1;
            if (best_per_ff == '0) begin
               live_ff[best_slot_ff] <= 1'b0;
            end
         end
         if (dp_cmd.emit && (dp_cmd.emit_kind == tpq_pkg::KIND_ADD) && found) begin
            live_ff[free_idx] <= 1'b1;
            gen_ff[free_idx]  <= gen_rd + 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (dp_cmd.latch) begin
         cmd_ff <= tpq_pkg::cmd_type'(req_cmd);
         tv_ff  <= req_time_value;
         ri_ff  <= req_repeat_interval;
         hs_ff  <= req_handle_slot;
         hg_ff  <= req_handle_generation;
      end
      if (dp_cmd.scan_step && better) begin
         best_ff      <= val;
         best_slot_ff <= idx_ff;
         best_per_ff  <= rd_per;
      end
      if (dp_cmd.cancel_do) begin
         ok_ff <= hit;
      end
      if (dp_cmd.tick_save) begin
         nxt_ff <= any_ff ? best_ff : '0;
         nv_ff  <= any_ff;
      end
      if (dp_cmd.pick_update && (best_per_ff != '0)) begin
         exp_ff[best_slot_ff] <= resched;
      end
      if (dp_cmd.emit && (dp_cmd.emit_kind == tpq_pkg::KIND_ADD) && found) begin
         exp_ff[free_idx] <= tv_ff;
         per_ff[free_idx] <= ri_ff;
      end
      // Result fields by kind.
      if (dp_cmd.emit) begin
         rsp_result_kind     <= dp_cmd.emit_kind;
         rsp_became_earliest <= 1'b0;
         rsp_out_slot        <= '0;
         rsp_out_generation  <= '0;
         rsp_success         <= 1'b1;
         rsp_last            <= 1'b1;
         rsp_next_expiry     <= nxt_ff;
         rsp_next_valid      <= nv_ff;
         unique case (dp_cmd.emit_kind)
            tpq_pkg::KIND_ADD: begin
               rsp_out_slot        <= found ? SW'(free_idx) : '0;
               rsp_out_generation  <= found ? gen_rd + 1'b1 : '0;
               rsp_success         <= found;
               rsp_became_earliest <= early;
               rsp_next_expiry     <= add_next;
               rsp_next_valid      <= any_ff || found;
            end
            tpq_pkg::KIND_EXPIRED: begin
               rsp_out_slot       <= SW'(best_slot_ff);
               rsp_out_generation <= gen_rd;
               rsp_last           <= 1'b0;
            end
            tpq_pkg::KIND_CANCEL: begin
               rsp_success     <= ok_ff;
               rsp_next_expiry <= any_ff ? best_ff : '0;
               rsp_next_valid  <= any_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

/* src/tpq_ctrl.sv */
// Controller state machine of the timer priority queue.
module tpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_cmd,
   input  tpq_pkg::dp_status_type dp_status,
   output tpq_pkg::dp_cmd_type    dp_cmd,
   output logic                   busy
);

   tpq_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      dp_cmd.scan_mode = tpq_pkg::SCAN_PLAIN;
      dp_cmd.emit_kind = tpq_pkg::KIND_FIN;
      busy      = (state_ff != tpq_pkg::S_IDLE);
      unique case (state_ff)
         tpq_pkg::S_IDLE: begin
            if (start) begin
               dp_cmd.latch      = 1'b1;
               dp_cmd.scan_clear = 1'b1;
               unique case (tpq_pkg::cmd_type'(req_cmd))
                  tpq_pkg::CMD_ADD:    state_in = tpq_pkg::S_ADD_SCAN;
                  tpq_pkg::CMD_CANCEL: state_in = tpq_pkg::S_CAN_DO;
                  tpq_pkg::CMD_TICK:   state_in = tpq_pkg::S_TNEXT_SCAN;
                  default:             state_in = tpq_pkg::S_IDLE;
               endcase
            end
         end
         tpq_pkg::S_ADD_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (dp_status.scan_last) state_in = tpq_pkg::S_ADD_FIN;
         end
         tpq_pkg::S_ADD_FIN: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.emit_kind = tpq_pkg::KIND_ADD;
            state_in         = tpq_pkg::S_IDLE;
         end
         tpq_pkg::S_CAN_DO: begin
            dp_cmd.cancel_do = 1'b1;
            state_in         = tpq_pkg::S_CAN_SCAN;
         end
         tpq_pkg::S_CAN_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (dp_status.scan_last) state_in = tpq_pkg::S_CAN_FIN;
         end
         tpq_pkg::S_CAN_FIN: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.emit_kind = tpq_pkg::KIND_CANCEL;
            state_in         = tpq_pkg::S_IDLE;
         end
         tpq_pkg::S_TNEXT_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            dp_cmd.scan_mode = tpq_pkg::SCAN_NEXT;
            if (dp_status.scan_last) state_in = tpq_pkg::S_TPREP;
         end
         tpq_pkg::S_TPREP: begin
            dp_cmd.tick_save  = 1'b1;
            dp_cmd.scan_clear = 1'b1;
            state_in          = tpq_pkg::S_TDUE_SCAN;
         end
         tpq_pkg::S_TDUE_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            dp_cmd.scan_mode = tpq_pkg::SCAN_DUE;
            if (dp_status.scan_last) state_in = tpq_pkg::S_TPICK;
         end
         tpq_pkg::S_TPICK: begin
            dp_cmd.emit = 1'b1;
            if (dp_status.any) begin
               dp_cmd.emit_kind   = tpq_pkg::KIND_EXPIRED;
               dp_cmd.pick_update = 1'b1;
               dp_cmd.scan_clear  = 1'b1;
               state_in           = tpq_pkg::S_TDUE_SCAN;
            end else begin
               state_in = tpq_pkg::S_IDLE;
            end
         end
         default: state_in = tpq_pkg::S_IDLE;
      endcase
   end

endmodule

/* src/timer_priority_queue_top.sv */
// Top level of the timer priority queue.
//
// A request is taken at a rising edge with start high and busy low; busy
// stays high until the cycle that shows the last result of that request.
// Results appear for one cycle each with rsp_valid high; rsp_last marks the
// final one. The receiver cannot stall, so every result is taken as shown.
// An add or a cancel scans every slot once for the earliest expiry and
// then answers with a single result.
// A tick first scans all slots for the expiry left after rescheduling,
// then runs one selection scan over all slots per due timer, plus a final
// scan that finds none and ends the tick; each scan reads a single slot
// at a time.
// Command code 3 is taken and dropped with no result.
// Reset clears all slots and generation tags at once; the block is ready
// in the cycle after reset falls.
module timer_priority_queue_top #(
   parameter int CAPACITY = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic [tpq_pkg::TIME_W-1:0] req_time_value,
   input  logic [tpq_pkg::PER_W-1:0]  req_repeat_interval,
   input  logic [tpq_pkg::SLOT_W-1:0] req_handle_slot,
   input  logic [tpq_pkg::GEN_W-1:0]  req_handle_generation,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_result_kind,
   output logic [tpq_pkg::SLOT_W-1:0] rsp_out_slot,
   output logic [tpq_pkg::GEN_W-1:0]  rsp_out_generation,
   output logic                       rsp_success,
   output logic                       rsp_became_earliest,
   output logic [tpq_pkg::TIME_W-1:0] rsp_next_expiry,
   output logic                       rsp_next_valid,
   output logic                       rsp_last
);

   tpq_pkg::dp_cmd_type    dp_cmd;
   tpq_pkg::dp_status_type dp_status;

   tpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   tpq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_cmd               (req_cmd),
      .req_time_value        (req_time_value),
      .req_repeat_interval   (req_repeat_interval),
      .req_handle_slot       (req_handle_slot),
      .req_handle_generation (req_handle_generation),
      .dp_cmd                (dp_cmd),
      .dp_status             (dp_status),
      .rsp_valid             (rsp_valid),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_out_slot          (rsp_out_slot),
      .rsp_out_generation    (rsp_out_generation),
      .rsp_success           (rsp_success),
      .rsp_became_earliest   (rsp_became_earliest),
      .rsp_next_expiry       (rsp_next_expiry),
      .rsp_next_valid        (rsp_next_valid),
      .rsp_last              (rsp_last)
   );

   // A result only follows a cycle in which a request was in progress.
   a_rsp_in_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result shown with no request in progress");

   // The last result of a request frees the block.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy after the last result");

   // An unknown command is dropped without a result.
   a_unknown_dropped: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == 2'd3)) |=> (!busy && !rsp_valid))
      else $error("unknown command caused activity");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the timer priority queue: queued requests, clocked driver and monitor.
module testbench;

   localparam int SLOTS = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TW = tpq_pkg::TIME_W;
   localparam int PW = tpq_pkg::PER_W;
   localparam int SW = tpq_pkg::SLOT_W;
   localparam int GW = tpq_pkg::GEN_W;

   typedef struct {
      tpq_pkg::cmd_type    cmd;
      logic [TW-1:0]       tv;
      logic [PW-1:0]       ri;
      logic [SW-1:0]       hs;
      logic [GW-1:0]       hg;
      int                  gap;
      bit                  drain;
   } timer_req_type;

   typedef struct {
      tpq_pkg::kind_type kind;
      logic [SW-1:0]     slot;
      logic [GW-1:0]     gen;
      bit                ok;
      bit                early;
      logic [TW-1:0]     nxt;
      bit                nv;
      bit                lst;
   } timer_rsp_type;

   // Two copies of the queue state: one checks the block, one steers stimulus.
   typedef struct {
      bit                live [SLOTS];
      logic [TW-1:0]     expiry [SLOTS];
      logic [PW-1:0]     per [SLOTS];
      logic [GW-1:0]     gen [SLOTS];
   } queue_state_type;

   localparam int CHECK_COPY = 0;
   localparam int STIM_COPY  = 1;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0]        req_cmd = tpq_pkg::CMD_NONE;
   logic [TW-1:0]     req_time_value = '0;
   logic [PW-1:0]     req_repeat_interval = '0;
   logic [SW-1:0]     req_handle_slot = '0;
   logic [GW-1:0]     req_handle_generation = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_result_kind;
   logic [SW-1:0]     rsp_out_slot;
   logic [GW-1:0]     rsp_out_generation;
   logic              rsp_success;
   logic              rsp_became_earliest;
   logic [TW-1:0]     rsp_next_expiry;
   logic              rsp_next_valid;
   logic              rsp_last;

   queue_state_type queue_copy [2];
   timer_req_type   pending_requests [$];
   timer_rsp_type   expected_results [$];
   int errors = 0;
   int issued_n = 0;
   int accepted_n = 0;
   int idle_cycles = 0;
   int settle = 0;

   timer_priority_queue_top #(.CAPACITY(SLOTS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_time_value(req_time_value),
      .req_repeat_interval(req_repeat_interval), .req_handle_slot(req_handle_slot),
      .req_handle_generation(req_handle_generation),
      .rsp_valid(rsp_valid), .rsp_result_kind(rsp_result_kind),
      .rsp_out_slot(rsp_out_slot), .rsp_out_generation(rsp_out_generation),
      .rsp_success(rsp_success), .rsp_became_earliest(rsp_became_earliest),
      .rsp_next_expiry(rsp_next_expiry), .rsp_next_valid(rsp_next_valid),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Earliest pending expiry in one copy of the state.
   function automatic bit earliest_expiry(input int w, output logic [TW-1:0] t);
      bit any;
      any = 0;
      t = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (queue_copy[w].live[i] && (!any || queue_copy[w].expiry[i] < t)) begin
            t = queue_copy[w].expiry[i];
            any = 1;
         end
      end
      return any;
   endfunction

   // Applies one request to a copy of the state; the checking copy also
   // records the results that the block must produce.
   function automatic void apply_request(input int w, input timer_req_type r);
      timer_rsp_type res;
      timer_rsp_type outs [$];
      bit due [SLOTS];
      int order [$];
      int free_slot;
      int pick;
      bit any;
      logic [TW-1:0] cur;
      logic [TW:0] sum;
      res = '{tpq_pkg::KIND_ADD, '0, '0, 1, 0, '0, 0, 1};
      case (r.cmd)
         tpq_pkg::CMD_ADD: begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!queue_copy[w].live[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               res.ok = 0;
            end else begin
               any = earliest_expiry(w, cur);
               res.early = !any || r.tv < cur;
               queue_copy[w].gen[free_slot] = queue_copy[w].gen[free_slot] + 1'b1;
               queue_copy[w].live[free_slot] = 1;
               queue_copy[w].expiry[free_slot] = r.tv;
               queue_copy[w].per[free_slot] = r.ri;
               res.slot = SW'(free_slot);
               res.gen = queue_copy[w].gen[free_slot];
            end
            res.nv = earliest_expiry(w, res.nxt);
            outs.push_back(res);
         end
         tpq_pkg::CMD_CANCEL: begin
            res.kind = tpq_pkg::KIND_CANCEL;
            res.ok = queue_copy[w].live[r.hs] && queue_copy[w].gen[r.hs] == r.hg;
            if (res.ok) queue_copy[w].live[r.hs] = 0;
            res.nv = earliest_expiry(w, res.nxt);
            outs.push_back(res);
         end
         tpq_pkg::CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++)
               due[i] = queue_copy[w].live[i] && queue_copy[w].expiry[i] <= r.tv;
            // Order due timers by expiry, ties going to the lower slot.
            forever begin
               pick = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (due[i] && (pick < 0 ||
                      queue_copy[w].expiry[i] < queue_copy[w].expiry[pick]))
                     pick = i;
               end
               if (pick < 0) break;
               due[pick] = 0;
               order.push_back(pick);
            end
            foreach (order[k]) begin
               if (queue_copy[w].per[order[k]] != 0) begin
                  sum = {1'b0, r.tv} + (TW+1)'(queue_copy[w].per[order[k]]);
                  queue_copy[w].expiry[order[k]] =
                     sum[TW] ? tpq_pkg::TIME_MAX : sum[TW-1:0];
               end else begin
                  queue_copy[w].live[order[k]] = 0;
               end
            end
            res.nv = earliest_expiry(w, res.nxt);
            res.kind = tpq_pkg::KIND_EXPIRED;
            res.lst = 0;
            foreach (order[k]) begin
               res.slot = SW'(order[k]);
               res.gen = queue_copy[w].gen[order[k]];
               outs.push_back(res);
            end
            res.kind = tpq_pkg::KIND_FIN;
            res.slot = '0;
            res.gen = '0;
            res.lst = 1;
            outs.push_back(res);
         end
         default: ;
      endcase
      if (w == CHECK_COPY) begin
         foreach (outs[k]) expected_results.push_back(outs[k]);
      end
   endfunction

   // Queues one request and keeps the stimulus copy of the state in step.
   function automatic void queue_request(input tpq_pkg::cmd_type cmd, input logic [TW-1:0] tv,
                                         input logic [PW-1:0] ri, input logic [SW-1:0] hs,
                                         input logic [GW-1:0] hg, input int gap,
                                         input bit drain);
      timer_req_type r;
      r = '{cmd, tv, ri, hs, hg, gap, drain};
      apply_request(STIM_COPY, r);
      pending_requests.push_back(r);
   endfunction

   // Drive requests at the falling edge.
   timer_req_type next_req;
   bit have_next = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (!start || accepted_n == issued_n)) begin
         if (!have_next && pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            gap_left = next_req.gap;
            have_next = 1;
         end
         if (have_next && gap_left == 0 &&
             (!next_req.drain || (expected_results.size() == 0 && settle >= SETTLE_CYCLES))) begin
            req_cmd <= next_req.cmd;
            req_time_value <= next_req.tv;
            req_repeat_interval <= next_req.ri;
            req_handle_slot <= next_req.hs;
            req_handle_generation <= next_req.hg;
            start <= 1;
            issued_n = issued_n + 1;
            have_next = 0;
         end else begin
            start <= 0;
            if (have_next && gap_left > 0) gap_left = gap_left - 1;
         end
      end
   end

   // Take requests and check results at the rising edge.
   timer_rsp_type want;
   timer_req_type taken;
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            taken = '{tpq_pkg::cmd_type'(req_cmd), req_time_value, req_repeat_interval,
                      req_handle_slot, req_handle_generation, 0, 0};
            apply_request(CHECK_COPY, taken);
            accepted_n <= accepted_n + 1;
         end
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result kind %0d slot %0d", $time,
                        rsp_result_kind, rsp_out_slot);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind || rsp_out_slot !== want.slot ||
                   rsp_out_generation !== want.gen || rsp_success !== want.ok ||
                   rsp_became_earliest !== want.early || rsp_next_expiry !== want.nxt ||
                   rsp_next_valid !== want.nv || rsp_last !== want.lst) begin
                  $display("%0t: expected kind %0d slot %0d gen %0d ok %0d early %0d next %0h nv %0d last %0d",
                           $time, want.kind, want.slot, want.gen, want.ok, want.early,
                           want.nxt, want.nv, want.lst);
                  $display("%0t: actual   kind %0d slot %0d gen %0d ok %0d early %0d next %0h nv %0d last %0d",
                           $time, rsp_result_kind, rsp_out_slot, rsp_out_generation,
                           rsp_success, rsp_became_earliest, rsp_next_expiry,
                           rsp_next_valid, rsp_last);
                  errors++;
               end
            end
         end
         // Idle and settle counters, one update each per edge.
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (start && !busy) begin
            settle <= 0;
         end else begin
            settle <= (expected_results.size() == 0 && !busy) ? settle + 1 : 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Stimulus, then the final verdict.
   logic [TW-1:0] now;
   int pick_slot;
   int gap_mode;
   int count;
   int roll;
   logic [TW-1:0] tv;
   logic [PW-1:0] ri;
   initial begin
      for (int w = 0; w < 2; w++) begin
         for (int i = 0; i < SLOTS; i++) begin
            queue_copy[w].live[i] = 0;
            queue_copy[w].gen[i] = '0;
            queue_copy[w].expiry[i] = '0;
            queue_copy[w].per[i] = '0;
         end
      end

      // Directed part: extremes, ties, cancel misses, saturation, unknown command.
      queue_request(tpq_pkg::CMD_TICK, '0, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_ADD, 100, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_ADD, 100, 5, '0, '0, 1, 0);
      queue_request(tpq_pkg::CMD_ADD, 50, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_ADD, tpq_pkg::TIME_MAX, {PW{1'b1}}, '0, '0, 3, 0);
      queue_request(tpq_pkg::CMD_ADD, '0, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_CANCEL, '0, '0, 5'd1, 16'd2, 0, 0);
      queue_request(tpq_pkg::CMD_CANCEL, '0, '0, 5'd1, 16'd1, 0, 0);
      queue_request(tpq_pkg::CMD_CANCEL, '0, '0, 5'd1, 16'd1, 2, 0);
      queue_request(tpq_pkg::CMD_CANCEL, '0, '0, 5'd31, 16'hFFFF, 0, 0);
      queue_request(tpq_pkg::CMD_NONE, tpq_pkg::TIME_MAX, {PW{1'b1}}, 5'd31, 16'hFFFF, 0, 0);
      queue_request(tpq_pkg::CMD_TICK, 100, '0, '0, '0, 0, 1);
      queue_request(tpq_pkg::CMD_TICK, tpq_pkg::TIME_MAX - 3, '0, '0, '0, 4, 0);
      queue_request(tpq_pkg::CMD_TICK, tpq_pkg::TIME_MAX, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_CANCEL, '0, '0, 5'd4, 16'd1, 0, 0);
      queue_request(tpq_pkg::CMD_TICK, tpq_pkg::TIME_MAX, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_ADD, 10, 7, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_ADD, 10, 3, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_ADD, 9, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_TICK, 20, '0, '0, '0, 0, 0);
      queue_request(tpq_pkg::CMD_TICK, 40, '0, '0, '0, 0, 1);

      // Random part: mostly timers near a running clock, some wide noise.
      now = 40;
      count = 0;
      gap_mode = 0;
      while (count < 350) begin
         if (count % 20 == 0) gap_mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         if (count == 100) begin
            // Fill every slot and overflow at least once.
            for (int i = 0; i <= SLOTS; i++)
               queue_request(tpq_pkg::CMD_ADD, now + TW'($urandom_range(0, 500)),
                             PW'($urandom_range(0, 1) ? $urandom_range(1, 200) : 0),
                             '0, '0, 0, 0);
            count += SLOTS + 1;
         end else if (roll < 40) begin
            tv = now + TW'($urandom_range(0, 200));
            ri = PW'($urandom_range(0, 1) ? $urandom_range(1, 300) : 0);
            if ($urandom_range(0, 19) == 0) tv = TW'({$urandom, $urandom});
            if ($urandom_range(0, 19) == 0) ri = PW'({$urandom, $urandom});
            queue_request(tpq_pkg::CMD_ADD, tv, ri, SW'($urandom), GW'($urandom),
                          gap_mode == 0 ? 0 : $urandom_range(0, 15), count % 60 == 59);
         end else if (roll < 60) begin
            pick_slot = $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 9) < 7) begin
               queue_request(tpq_pkg::CMD_CANCEL, TW'($urandom), PW'($urandom),
                             SW'(pick_slot), queue_copy[STIM_COPY].gen[pick_slot],
                             gap_mode == 0 ? 0 : $urandom_range(0, 15), 0);
            end else begin
               queue_request(tpq_pkg::CMD_CANCEL, TW'({$urandom, $urandom}),
                             PW'({$urandom, $urandom}), SW'($urandom), GW'($urandom),
                             gap_mode == 0 ? 0 : $urandom_range(0, 15), 0);
            end
         end else if (roll < 95) begin
            now = now + TW'($urandom_range(0, 150));
            tv = ($urandom_range(0, 24) == 0) ? TW'({$urandom, $urandom}) : now;
            queue_request(tpq_pkg::CMD_TICK, tv, PW'($urandom), SW'($urandom),
                          GW'($urandom), gap_mode == 0 ? 0 : $urandom_range(0, 15), 0);
         end else begin
            queue_request(tpq_pkg::CMD_NONE, TW'({$urandom, $urandom}),
                          PW'({$urandom, $urandom}), SW'($urandom), GW'($urandom),
                          gap_mode == 0 ? 0 : $urandom_range(0, 15), 0);
         end
         count++;
      end
      queue_request(tpq_pkg::CMD_TICK, tpq_pkg::TIME_MAX, '0, '0, '0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 0;

      wait (pending_requests.size() == 0 && !have_next && accepted_n == issued_n);
      wait (expected_results.size() == 0);
      repeat (2 * SLOTS + 20) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
